FILE: design/t9_contact_substring_match_unit_assert.svh
// assertion macros for the t9 contact substring match unit
`ifndef T9_CONTACT_SUBSTRING_MATCH_UNIT_ASSERT_SVH
`define T9_CONTACT_SUBSTRING_MATCH_UNIT_ASSERT_SVH

// checked on every clock edge outside reset
`define T9CSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("t9csm assertion failed");

// checked on every clock edge, reset included
`define T9CSM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("t9csm assertion failed");

`endif

FILE: design/t9csm_pkg.sv
// shared constants and types of the t9 contact substring match unit
package t9csm_pkg;

  localparam int unsigned QueryMax  = 16;
  localparam int unsigned FieldMax  = 100;
  localparam int unsigned WinDepth  = QueryMax;
  localparam int unsigned SymW      = 4;
  localparam int unsigned QIdxW     = $clog2(QueryMax);
  localparam int unsigned QLenW     = 5;
  localparam int unsigned CntW      = 7;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CharW     = 8;

  typedef logic [SymW-1:0] sym_t;

  localparam sym_t SymInvalid = sym_t'(15);
  localparam sym_t DigitMax   = sym_t'(9);

  typedef enum logic {
    CfgQueryDigits = 1'b0,
    CfgQueryLength = 1'b1
  } cfg_idx_e;

endpackage

FILE: design/t9csm_if.sv
// valid/ready channels carrying input and result words
interface t9csm_in_if;
  logic                          valid;
  logic                          ready;
  logic [t9csm_pkg::CharW-1:0]   character;
  logic                          in_number_field;
  logic                          field_start;
  logic                          record_end;

  modport source (output valid, output character, output in_number_field,
                  output field_start, output record_end, input ready);
  modport sink   (input valid, input character, input in_number_field,
                  input field_start, input record_end, output ready);
endinterface

interface t9csm_out_if;
  logic valid;
  logic ready;
  logic record_match;
  logic any_found;
  logic field_too_long;
  logic record_done;

  modport source (output valid, output record_match, output any_found,
                  output field_too_long, output record_done, input ready);
  modport sink   (input valid, input record_match, input any_found,
                  input field_too_long, input record_done, output ready);
endinterface

FILE: design/t9csm_keymap.sv
// maps a raw character to its keypad symbol
module t9csm_keymap (
  input  logic [t9csm_pkg::CharW-1:0] char_i,
  input  logic                        number_field_i,
  output t9csm_pkg::sym_t             sym_o
);

  logic [t9csm_pkg::CharW-1:0] lower;

  always_comb begin
    if (char_i inside {[8'h41:8'h5a]}) begin
      lower = char_i + 8'd32;
    end else begin
      lower = char_i;
    end
  end

  always_comb begin
    if (number_field_i) begin
      if (char_i inside {[8'h30:8'h39]}) begin
        sym_o = t9csm_pkg::sym_t'(char_i - 8'h30);
      end else begin
        sym_o = t9csm_pkg::SymInvalid;
      end
    end else begin
      case (lower) inside
        [8'h61:8'h63]: sym_o = t9csm_pkg::sym_t'(2);
        [8'h64:8'h66]: sym_o = t9csm_pkg::sym_t'(3);
        [8'h67:8'h69]: sym_o = t9csm_pkg::sym_t'(4);
        [8'h6a:8'h6c]: sym_o = t9csm_pkg::sym_t'(5);
        [8'h6d:8'h6f]: sym_o = t9csm_pkg::sym_t'(6);
        [8'h70:8'h73]: sym_o = t9csm_pkg::sym_t'(7);
        [8'h74:8'h76]: sym_o = t9csm_pkg::sym_t'(8);
        [8'h77:8'h7a]: sym_o = t9csm_pkg::sym_t'(9);
        8'h2b:         sym_o = t9csm_pkg::sym_t'(0);
        default:       sym_o = t9csm_pkg::SymInvalid;
      endcase
    end
  end

endmodule

FILE: design/t9_contact_substring_match_unit.sv
// top level of the t9 contact substring match unit
//
//  channel  dir  handshake      word
//  in_i     in   valid/ready    character, in_number_field, field_start, record_end
//  out_o    out  valid/ready    record_match, any_found, field_too_long, record_done
//  cfg      in   cfg_we_i       cfg_idx_i selects query digits or query length
//
//  one word accepted per cycle; its result appears in the output register the next cycle
//  the parallel window compare reads the updated symbol window, so each word's match goes into that register
//  input stalls only while a result waits in the output register and out_o.ready is low
//  reset leaves the window all invalid, counters and flags cleared, query empty
module t9_contact_substring_match_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  t9csm_in_if.sink                        in_i,
  t9csm_out_if.source                     out_o,
  input  logic                            cfg_we_i,
  input  t9csm_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [t9csm_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  `include "t9_contact_substring_match_unit_assert.svh"

  logic [t9csm_pkg::QueryMax-1:0][t9csm_pkg::SymW-1:0] query_q;
  logic [t9csm_pkg::QLenW-1:0]                         qlen_q;
  t9csm_pkg::sym_t [t9csm_pkg::WinDepth-1:0]           win_q, win_d;
  logic [t9csm_pkg::CntW-1:0]                          cnt_q, cnt_d;
  logic                                                too_long_q, too_long_d;
  logic                                                match_q, match_d;
  logic                                                found_q, found_d;
  logic                                                out_valid_q;
  logic                                                out_match_q, out_found_q;
  logic                                                out_long_q, out_done_q;

  t9csm_pkg::sym_t                                     sym;
  logic [t9csm_pkg::QLenW-1:0]                         len_eff;
  logic [t9csm_pkg::WinDepth-1:0]                      pos_ok;
  logic                                                win_hit;
  logic                                                rec_match;
  logic                                                in_acc;
  logic [t9csm_pkg::CntW-1:0]                          cnt_base;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
      qlen_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        t9csm_pkg::CfgQueryDigits: query_q <= cfg_wdata_i;
        t9csm_pkg::CfgQueryLength: qlen_q  <= cfg_wdata_i[t9csm_pkg::QLenW-1:0];
        default: ;
      endcase
    end
  end

  t9csm_keymap u_keymap (
    .char_i         (in_i.character),
    .number_field_i (in_i.in_number_field),
    .sym_o          (sym)
  );

  // window shift, field start flushes old symbols
  always_comb begin
    win_d[0] = sym;
    for (int k = 1; k < t9csm_pkg::WinDepth; k++) begin
      win_d[k] = in_i.field_start ? t9csm_pkg::SymInvalid : win_q[k-1];
    end
  end

  assign len_eff = (qlen_q > t9csm_pkg::QLenW'(t9csm_pkg::QueryMax)) ?
                   t9csm_pkg::QLenW'(t9csm_pkg::QueryMax) : qlen_q;

  // newest symbol lines up with the last query digit
  always_comb begin
    logic [t9csm_pkg::QLenW-1:0] idx;
    for (int k = 0; k < t9csm_pkg::WinDepth; k++) begin
      idx = len_eff - t9csm_pkg::QLenW'(k) - t9csm_pkg::QLenW'(1);
      if (t9csm_pkg::QLenW'(k) < len_eff) begin
        pos_ok[k] = (win_d[k] <= t9csm_pkg::DigitMax) &&
                    (win_d[k] == query_q[idx[t9csm_pkg::QIdxW-1:0]]);
      end else begin
        pos_ok[k] = 1'b1;
      end
    end
  end

  assign win_hit   = &pos_ok;
  assign rec_match = match_q || win_hit;

  // field length count
  always_comb begin
    cnt_base   = in_i.field_start ? '0 : cnt_q;
    too_long_d = in_i.field_start ? 1'b0 : too_long_q;
    cnt_d      = cnt_base;
    if (cnt_base >= t9csm_pkg::CntW'(t9csm_pkg::FieldMax)) begin
      too_long_d = 1'b1;
    end else begin
      cnt_d = cnt_base + t9csm_pkg::CntW'(1);
    end
  end

  assign match_d = in_i.record_end ? 1'b0 : rec_match;
  assign found_d = found_q || win_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= {t9csm_pkg::WinDepth{t9csm_pkg::SymInvalid}};
      cnt_q      <= '0;
      too_long_q <= 1'b0;
      match_q    <= 1'b0;
      found_q    <= 1'b0;
    end else if (in_acc) begin
      win_q      <= win_d;
      cnt_q      <= cnt_d;
      too_long_q <= too_long_d;
      match_q    <= match_d;
      found_q    <= found_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_match_q <= rec_match;
      out_found_q <= found_d;
      out_long_q  <= too_long_d;
      out_done_q  <= in_i.record_end;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.record_match   = out_match_q;
  assign out_o.any_found      = out_found_q;
  assign out_o.field_too_long = out_long_q;
  assign out_o.record_done    = out_done_q;

  `T9CSM_ASSERT(a_found_sticky, found_q |=> found_q)
  `T9CSM_ASSERT(a_rec_end_clears, (in_acc && in_i.record_end) |=> !match_q)
  `T9CSM_ASSERT(a_cnt_bound, cnt_q <= t9csm_pkg::CntW'(t9csm_pkg::FieldMax))
  `T9CSM_ASSERT(a_long_at_max,
                !too_long_q || (cnt_q == t9csm_pkg::CntW'(t9csm_pkg::FieldMax)))
  `T9CSM_ASSERT(a_match_sets_found, out_valid_q |-> (!out_match_q || out_found_q))

endmodule
